FILE: hw/rtl/wbb_pkg.sv
// Shared types, constants and codes for the weighted blur and blend filter.
package wbb_pkg;

	// Default frame limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Configuration port
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 13;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int FRAME_WIDTH_RST  = 1024;
	localparam int FRAME_HEIGHT_RST = 768;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Request type code
	localparam logic REQ_FLUSH = 1'b1;

	// Datapath widths
	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int SUM_W = 13;  // 17 * 255 fits
	localparam int MIX_W = 16;  // 255 * 255 fits

	// Kernel weights and arithmetic constants
	localparam int KERNEL_CENTER = 5;
	localparam int KERNEL_SIDE   = 2;
	localparam int DIV_BLUR      = 17;
	localparam int RECIP_W       = 12;
	localparam int RECIP_SHIFT   = 16;
	localparam int RECIP_17      = 3855;  // floor(2^16 / 17)
	localparam int BLEND_ORIG    = 96;
	localparam int BLEND_BLUR    = 159;
	localparam int DIV_MIX       = 255;

	// Queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [2:0][2:0] win_t;  // [row: top..bottom][col: left..right]

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} edge_t;

	typedef struct packed {
		win_t  win;
		edge_t edges;
	} job_t;

	typedef struct packed {
		logic            req_type;
		logic [CH_W-1:0] in_blue;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_red;
	} pix_req_t;

	typedef struct packed {
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_red;
		logic            frame_done;
	} pix_res_t;

endpackage

FILE: hw/rtl/weighted_blur_blend_filter_core.sv
// The item completing a pixel's window passes front stage 1, the queue and the back stages.
// That item is the one frame_width+1 positions after the pixel; flush items drain the tail.
// One item per cycle while the queue has room; each takes a line buffer read and a write.
// Reset: counters, valids and the window clear; frame_width=1024, frame_height=768.
// Line buffer contents are not cleared and hold whatever was last written.
module weighted_blur_blend_filter_core #(
	parameter int MAX_WIDTH  = wbb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = wbb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  wbb_pkg::pix_req_t                pix,
	output logic                             res_valid,
	input  logic                             res_ready,
	output wbb_pkg::pix_res_t                res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wbb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [wbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                         q_push, q_pop, q_head_valid;
	logic [wbb_pkg::QCNT_W-1:0]   q_count;
	wbb_pkg::job_t                q_job, q_head;

	assign cfg_ready = 1'b1;

	wbb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (q_push),
		.job       (q_job)
	);

	wbb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.job_in     (q_job),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid),
		.count      (q_count)
	);

	wbb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// queue never overflows under the front's credit check
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < wbb_pkg::QCNT_W'(wbb_pkg::QUEUE_DEPTH)) || q_pop)
		else $error("queue overflow");

	// back only pops a filled queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_count != '0)
		else $error("queue underflow");

	// front only takes an item while the queue has room
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready |-> q_count < wbb_pkg::QCNT_W'(wbb_pkg::QUEUE_DEPTH))
		else $error("front ready with full queue");

endmodule

FILE: hw/rtl/wbb_front.sv
// Front end: configuration, position tracking, line buffers and 3x3 window.
module wbb_front #(
	parameter int MAX_WIDTH  = wbb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = wbb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  wbb_pkg::pix_req_t                   pix,
	input  logic                                cfg_valid,
	input  logic [wbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [wbb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [wbb_pkg::QCNT_W-1:0]          q_count,
	output logic                                push,
	output wbb_pkg::job_t                       job
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = $clog2(MAX_HEIGHT + 3);
	localparam int W_RST = (wbb_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
		MAX_WIDTH : wbb_pkg::FRAME_WIDTH_RST;
	localparam int H_RST = (wbb_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
		MAX_HEIGHT : wbb_pkg::FRAME_HEIGHT_RST;
	localparam int LW    = 2 * wbb_pkg::PIX_W;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic                       accept;
	logic [WW-1:0]              w_wr;
	logic [HW-1:0]              h_wr;
	logic [wbb_pkg::FRAME_WIDTH_W-1:0]  cfg_w;
	logic [wbb_pkg::FRAME_HEIGHT_W-1:0] cfg_h;
	logic [RW-1:0]              h_ext, hp1, hp2, row_inc;
	logic [WW-1:0]              k_next;
	logic [CW-1:0]              col_nx;
	logic                       col_nz, wrap, terminal, produce;
	wbb_pkg::pix_t              px;
	wbb_pkg::edge_t             flags;

	// stage 1
	logic                       v_s1;
	logic                       produce_s1;
	wbb_pkg::pix_t              px_s1;
	logic [CW-1:0]              col_s1;
	wbb_pkg::edge_t             flags_s1;

	logic [LW-1:0]              line_mem [MAX_WIDTH];
	logic [LW-1:0]              rd_q;
	logic                       fwd_q;
	logic [LW-1:0]              fwd_data_q;
	logic [LW-1:0]              line_rd;
	wbb_pkg::pix_t              col_top, col_mid;
	wbb_pkg::win_t              win_q, win_nx;

	assign accept = pix_valid && pix_ready;

	// credit check: queue occupancy plus the item in stage 1
	assign pix_ready = ((wbb_pkg::QCNT_W+1)'(q_count) + (wbb_pkg::QCNT_W+1)'(v_s1))
		< (wbb_pkg::QCNT_W+1)'(wbb_pkg::QUEUE_DEPTH);

	// clamp register writes into the supported range
	assign cfg_w = cfg_data[wbb_pkg::FRAME_WIDTH_W-1:0];
	assign cfg_h = cfg_data[wbb_pkg::FRAME_HEIGHT_W-1:0];

	always_comb begin
		if (cfg_w == '0)
			w_wr = WW'(1);
		else if (cfg_w > MAX_WIDTH)
			w_wr = WW'(MAX_WIDTH);
		else
			w_wr = WW'(cfg_w);
		if (cfg_h == '0)
			h_wr = HW'(1);
		else if (cfg_h > MAX_HEIGHT)
			h_wr = HW'(MAX_HEIGHT);
		else
			h_wr = HW'(cfg_h);
	end

	// classify the arriving item from its position
	assign h_ext  = RW'(height_q);
	assign hp1    = h_ext + RW'(1);
	assign hp2    = h_ext + RW'(2);
	assign col_nz = (col_q != '0);
	assign k_next = WW'(col_q) + WW'(1);
	assign wrap   = (k_next >= width_q);
	assign col_nx = wrap ? '0 : k_next[CW-1:0];
	assign row_inc = wrap ? (row_q + RW'(1)) : row_q;

	always_comb begin
		// pixels count only while the frame's pixels are still arriving
		if ((row_q < h_ext) && (pix.req_type != wbb_pkg::REQ_FLUSH))
			px = {pix.in_red, pix.in_green, pix.in_blue};
		else
			px = '0;

		// output position trails by one row and one column
		if (col_nz) begin
			produce      = (row_q != '0) && (row_q <= h_ext);
			flags.top    = (row_q == RW'(1));
			flags.bottom = (row_q == h_ext);
			flags.left   = (col_q == CW'(1));
		end else begin
			produce      = (row_q >= RW'(2)) && (row_q <= hp1);
			flags.top    = (row_q == RW'(2));
			flags.bottom = (row_q == hp1);
			flags.left   = (width_q == WW'(1));
		end
		flags.right = !col_nz;
		flags.last  = flags.bottom && flags.right;

		// frame ends after w*h + w + 1 items
		if (width_q == WW'(1))
			terminal = (row_inc == hp2);
		else
			terminal = (row_inc == hp1) && (col_nx == CW'(1));
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
			col_q    <= '0;
			row_q    <= '0;
			v_s1     <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					wbb_pkg::REG_FRAME_WIDTH:  width_q  <= w_wr;
					wbb_pkg::REG_FRAME_HEIGHT: height_q <= h_wr;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (terminal) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_nx;
					row_q <= row_inc;
				end
			end
			v_s1 <= accept;
			if (accept)
				fwd_q <= v_s1 && (col_s1 == col_q);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			produce_s1 <= produce;
			px_s1      <= px;
			col_s1     <= col_q;
			flags_s1   <= flags;
			fwd_data_q <= {col_mid, px_s1};
		end
	end

	// line buffers: entry holds {upper, middle} for one column
	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= line_mem[col_q];
		if (v_s1)
			line_mem[col_s1] <= {col_mid, px_s1};
	end

	// same column read while being written (single-column frames)
	assign line_rd = fwd_q ? fwd_data_q : rd_q;
	assign col_top = line_rd[LW-1:wbb_pkg::PIX_W];
	assign col_mid = line_rd[wbb_pkg::PIX_W-1:0];

	// window shift
	always_comb begin
		for (int rr = 0; rr < 3; rr++) begin
			win_nx[rr][0] = win_q[rr][1];
			win_nx[rr][1] = win_q[rr][2];
		end
		win_nx[0][2] = col_top;
		win_nx[1][2] = col_mid;
		win_nx[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (v_s1)
			win_q <= win_nx;
	end

	assign push      = v_s1 && produce_s1;
	assign job.win   = win_nx;
	assign job.edges = flags_s1;

endmodule

FILE: hw/rtl/wbb_queue.sv
// Short queue of window jobs between the front and the back.
module wbb_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  wbb_pkg::job_t                 job_in,
	input  logic                          pop,
	output wbb_pkg::job_t                 head,
	output logic                          head_valid,
	output logic [wbb_pkg::QCNT_W-1:0]    count
);

	wbb_pkg::job_t                   entry_q [wbb_pkg::QUEUE_DEPTH];
	logic [wbb_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [wbb_pkg::QCNT_W-1:0]      count_q;

	// pointers wrap naturally at a power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + wbb_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + wbb_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + wbb_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - wbb_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= job_in;
	end

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

endmodule

FILE: hw/rtl/wbb_back.sv
// Back end: edge replication, kernel sum, divide by 17, blend, output register.
module wbb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  wbb_pkg::job_t     head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output wbb_pkg::pix_res_t res
);

	localparam int PW = wbb_pkg::SUM_W + wbb_pkg::RECIP_W;
	localparam int CW = wbb_pkg::CH_W;
	localparam int SW = wbb_pkg::SUM_W;
	localparam int MW = wbb_pkg::MIX_W;

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [2:0][SW-1:0] sum_s1, sum_s2;
	logic [2:0][CW-1:0] orig_s1, orig_s2;
	logic [2:0][CW-1:0] quo_s2;
	logic [2:0][MW-1:0] mix_s3;
	logic               last_s1, last_s2, last_s3;
	wbb_pkg::pix_res_t  res_s4;

	logic [2:0][SW-1:0] sum_c;
	logic [2:0][CW-1:0] quo_c;
	logic [2:0][MW-1:0] mix_c;
	logic [2:0][CW-1:0] out_c;

	// stall chain from the output back to the queue
	assign rdy4 = !v_s4 || res_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pop  = head_valid && rdy1;

	// edge replication and weighted 3x3 sum
	always_comb begin
		wbb_pkg::win_t w;
		logic [CW-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
		w = head.win;
		if (head.edges.top)
			w[0] = w[1];
		if (head.edges.bottom)
			w[2] = w[1];
		if (head.edges.left)
			for (int rr = 0; rr < 3; rr++) w[rr][0] = w[rr][1];
		if (head.edges.right)
			for (int rr = 0; rr < 3; rr++) w[rr][2] = w[rr][1];
		for (int ch = 0; ch < 3; ch++) begin
			p00 = w[0][0][ch*CW +: CW];
			p01 = w[0][1][ch*CW +: CW];
			p02 = w[0][2][ch*CW +: CW];
			p10 = w[1][0][ch*CW +: CW];
			p11 = w[1][1][ch*CW +: CW];
			p12 = w[1][2][ch*CW +: CW];
			p20 = w[2][0][ch*CW +: CW];
			p21 = w[2][1][ch*CW +: CW];
			p22 = w[2][2][ch*CW +: CW];
			sum_c[ch] = SW'(p11) * SW'(wbb_pkg::KERNEL_CENTER)
				+ (SW'(p10) + SW'(p12) + SW'(p01) + SW'(p21)) * SW'(wbb_pkg::KERNEL_SIDE)
				+ SW'(p00) + SW'(p02) + SW'(p20) + SW'(p22);
		end
	end

	// reciprocal estimate of sum / 17, at most one low
	always_comb begin
		logic [PW-1:0] prod;
		for (int ch = 0; ch < 3; ch++) begin
			prod = PW'(sum_s1[ch]) * PW'(wbb_pkg::RECIP_17);
			quo_c[ch] = prod[wbb_pkg::RECIP_SHIFT +: CW];
		end
	end

	// correct the quotient, then blend with the original pixel
	always_comb begin
		logic [SW-1:0] rem;
		logic [CW-1:0] blur;
		for (int ch = 0; ch < 3; ch++) begin
			rem  = sum_s2[ch] - SW'(quo_s2[ch]) * SW'(wbb_pkg::DIV_BLUR);
			blur = quo_s2[ch] + CW'(rem >= SW'(wbb_pkg::DIV_BLUR));
			mix_c[ch] = MW'(orig_s2[ch]) * MW'(wbb_pkg::BLEND_ORIG)
				+ MW'(blur) * MW'(wbb_pkg::BLEND_BLUR);
		end
	end

	// mix / 255: estimate (x + x/256) / 256, then one correction
	always_comb begin
		logic [MW-1:0] t;
		logic [MW-1:0] rem;
		logic [CW-1:0] q0;
		for (int ch = 0; ch < 3; ch++) begin
			t   = mix_s3[ch] + (mix_s3[ch] >> CW);
			q0  = t[MW-1:CW];
			rem = mix_s3[ch] - MW'(q0) * MW'(wbb_pkg::DIV_MIX);
			out_c[ch] = q0 + CW'(rem >= MW'(wbb_pkg::DIV_MIX));
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= head_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (rdy1 && head_valid) begin
			sum_s1  <= sum_c;
			for (int ch = 0; ch < 3; ch++)
				orig_s1[ch] <= head.win[1][1][ch*CW +: CW];
			last_s1 <= head.edges.last;
		end
		if (rdy2 && v_s1) begin
			sum_s2  <= sum_s1;
			quo_s2  <= quo_c;
			orig_s2 <= orig_s1;
			last_s2 <= last_s1;
		end
		if (rdy3 && v_s2) begin
			mix_s3  <= mix_c;
			last_s3 <= last_s2;
		end
		if (rdy4 && v_s3) begin
			res_s4.out_blue   <= out_c[0];
			res_s4.out_green  <= out_c[1];
			res_s4.out_red    <= out_c[2];
			res_s4.frame_done <= last_s3;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_s4;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the weighted blur and blend pixel filter core.
`timescale 1ns / 1ps

module tb_top;
	import wbb_pkg::*;

	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int MAX_H         = MAX_HEIGHT_DEF;
	localparam int SETTLE_CYCLES = 12;      // pipeline latency plus margin
	localparam int TAIL_CYCLES   = 20;
	localparam int STALL_LIMIT   = 4000;    // cycles with no handshake at all
	localparam int END_LIMIT     = 500000;
	localparam int RANDOM_ITEMS  = 520;
	localparam int PRINT_CAP     = 40;
	localparam logic REQ_PIXEL   = ~REQ_FLUSH;

	typedef enum logic [1:0] {FEED_ITEM, FEED_REG, FEED_DRAIN} feed_kind_e;

	typedef struct {
		feed_kind_e                kind;
		pix_req_t                  item;
		logic [CFG_INDEX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]     val;
	} feed_t;

	// DUT signals; the driven inputs are known from time zero
	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   pix_valid  = 1'b0;
	logic                   pix_ready;
	pix_req_t               pix        = '0;
	logic                   res_valid;
	logic                   res_ready  = 1'b0;
	pix_res_t               res;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index  = '0;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;

	// Stimulus and scoreboard
	feed_t       feed_q[$];
	pix_res_t    blend_expect_q[$];
	logic        pix_taken = 1'b0;
	logic        cfg_taken = 1'b0;
	int unsigned items_total;
	int unsigned items_issued;
	int unsigned since_item;
	int unsigned stall_cycles;
	int unsigned error_count;
	int unsigned results_checked;
	int unsigned frames_seen;
	int unsigned reg_writes;

	// Filter state mirror
	pix_t                      line_above [MAX_W] = '{default: '0};
	pix_t                      line_mid [MAX_W]   = '{default: '0};
	pix_t                      win_cur [3][3]     = '{default: '0};
	int unsigned               col_pos;
	int unsigned               row_pos;
	int unsigned               frame_items;
	logic [FRAME_WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RST;
	logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RST;

	weighted_blur_blend_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin : clock_gen
		forever #10 clk = ~clk;
	end

	// One line per mismatch, capped so a broken build stays readable
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < PRINT_CAP) begin
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		end
		error_count++;
	endtask

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned chan_of(input pix_t p, input int unsigned ch);
		return int'(p[ch*CH_W +: CH_W]);
	endfunction

	// Apply a register write: any write restarts the frame
	task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = val[FRAME_WIDTH_W-1:0];
		end else begin
			height_reg = val[FRAME_HEIGHT_W-1:0];
		end
		col_pos = 0;
		row_pos = 0;
		frame_items = 0;
	endtask

	// Advance the line stores and window by one item; queue the blended pixel it completes
	task automatic blend_predict(input pix_req_t it);
		int unsigned w, h, k, q, r, c, j, sum, blur, orig, mixed;
		pix_t px, col_top, col_mid;
		pix_t nb [3][3];
		pix_res_t want;
		logic [CH_W-1:0] chv [3];
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		k = col_pos % MAX_W;
		q = row_pos;
		px = '0;
		// late pixels act as flush, early flush as a black pixel
		if (frame_items < w * h && it.req_type != REQ_FLUSH) begin
			px = {it.in_red, it.in_green, it.in_blue};
		end
		col_top = line_above[k];
		col_mid = line_mid[k];
		line_above[k] = col_mid;
		line_mid[k] = px;
		for (j = 0; j < 3; j++) begin
			win_cur[j][0] = win_cur[j][1];
			win_cur[j][1] = win_cur[j][2];
		end
		win_cur[0][2] = col_top;
		win_cur[1][2] = col_mid;
		win_cur[2][2] = px;

		if (frame_items >= w + 1) begin
			if (k >= 1) begin
				r = q - 1;
				c = k - 1;
			end else begin
				r = q - 2;
				c = w - 1;
			end
			if (r < h) begin
				nb = win_cur;
				// clamp to edge
				for (j = 0; j < 3; j++) begin
					if (r == 0) nb[0][j] = nb[1][j];
					if (r == h - 1) nb[2][j] = nb[1][j];
				end
				for (j = 0; j < 3; j++) begin
					if (c == 0) nb[j][0] = nb[j][1];
					if (c == w - 1) nb[j][2] = nb[j][1];
				end
				for (j = 0; j < 3; j++) begin
					sum = KERNEL_CENTER * chan_of(nb[1][1], j)
						+ KERNEL_SIDE * (chan_of(nb[1][0], j) + chan_of(nb[1][2], j)
						+ chan_of(nb[0][1], j) + chan_of(nb[2][1], j))
						+ chan_of(nb[0][0], j) + chan_of(nb[0][2], j)
						+ chan_of(nb[2][0], j) + chan_of(nb[2][2], j);
					blur = sum / DIV_BLUR;
					orig = chan_of(win_cur[1][1], j);
					mixed = (orig * BLEND_ORIG + blur * BLEND_BLUR) / DIV_MIX;
					chv[j] = mixed[CH_W-1:0];
				end
				want.out_blue   = chv[0];
				want.out_green  = chv[1];
				want.out_red    = chv[2];
				want.frame_done = (r == h - 1 && c == w - 1);
				blend_expect_q.push_back(want);
			end
		end

		frame_items++;
		k++;
		if (k >= w) begin
			k = 0;
			q++;
		end
		col_pos = k;
		row_pos = q;
		if (frame_items >= w * h + w + 1) begin
			col_pos = 0;
			row_pos = 0;
			frame_items = 0;
		end
	endtask

	// Stimulus builders
	task automatic push_item(input logic kind, input logic [CH_W-1:0] b,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] r);
		feed_t f;
		f.kind = FEED_ITEM;
		f.item.req_type = kind;
		f.item.in_blue  = b;
		f.item.in_green = g;
		f.item.in_red   = r;
		f.idx = '0;
		f.val = '0;
		feed_q.push_back(f);
		items_total++;
	endtask

	task automatic push_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		feed_t f;
		f.kind = FEED_REG;
		f.item = '0;
		f.idx  = idx;
		f.val  = CFG_DATA_W'(val);
		feed_q.push_back(f);
	endtask

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	// A frame of w*h pixels then w+1 flush items, optionally cut short or noisy
	task automatic push_frame(input int unsigned w, input int unsigned h,
			input int unsigned noise_pct, input int unsigned n_items, input int drain_at);
		int unsigned n;
		logic kind;
		feed_t f;
		for (n = 0; n < n_items; n++) begin
			kind = (n < w * h) ? REQ_PIXEL : REQ_FLUSH;
			if ($urandom_range(99) < noise_pct) kind = ~kind;
			if (int'(n) == drain_at) begin
				f.kind = FEED_DRAIN;
				f.item = '0;
				f.idx  = '0;
				f.val  = '0;
				feed_q.push_back(f);
			end
			push_item(kind, rand_chan(), rand_chan(), rand_chan());
		end
	endtask

	// Sample handshakes and run the predictor at the rising edge
	always @(posedge clk) begin : monitor
		pix_res_t want;
		pix_taken <= pix_valid && pix_ready;
		cfg_taken <= cfg_valid && cfg_ready;
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (since_item < 1000) since_item++;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				reg_writes++;
			end
			if (pix_valid && pix_ready) begin
				blend_predict(pix);
				since_item = 0;
			end
			if (res_valid && res_ready) begin
				if (blend_expect_q.size() == 0) begin
					report_mismatch("unexpected result", res, '0);
				end else begin
					want = blend_expect_q.pop_front();
					if (res.out_blue !== want.out_blue)
						report_mismatch("out_blue", res.out_blue, want.out_blue);
					if (res.out_green !== want.out_green)
						report_mismatch("out_green", res.out_green, want.out_green);
					if (res.out_red !== want.out_red)
						report_mismatch("out_red", res.out_red, want.out_red);
					if (res.frame_done !== want.frame_done)
						report_mismatch("frame_done", res.frame_done, want.frame_done);
					results_checked++;
					if (want.frame_done) frames_seen++;
				end
			end
		end
	end

	// Drive items, register writes and backpressure at the falling edge
	always @(negedge clk) begin : driver
		feed_t    head;
		logic     nv, ncv;
		pix_req_t np;
		int       send_idle, recv_idle;
		nv  = pix_valid;
		ncv = cfg_valid;
		np  = pix;
		// idle mix: sender light / receiver heavy, then swapped, then none
		if (items_issued < items_total / 3) begin
			send_idle = 17;
			recv_idle = 76;
		end else if (items_issued < 2 * items_total / 3) begin
			send_idle = 76;
			recv_idle = 17;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		if (arst_n) begin
			if (pix_valid && pix_taken) nv = 1'b0;
			if (cfg_valid && cfg_taken) ncv = 1'b0;
			if (!nv && !ncv && feed_q.size() != 0) begin
				head = feed_q[0];
				case (head.kind)
					FEED_ITEM: begin
						if ($urandom_range(99) >= send_idle) begin
							np = head.item;
							nv = 1'b1;
							void'(feed_q.pop_front());
							items_issued++;
						end
					end
					FEED_REG: begin
						// block must be idle before a write
						if (blend_expect_q.size() == 0 && since_item >= SETTLE_CYCLES) begin
							cfg_index <= head.idx;
							cfg_data  <= head.val;
							ncv = 1'b1;
							void'(feed_q.pop_front());
						end
					end
					default: begin
						if (blend_expect_q.size() == 0) void'(feed_q.pop_front());
					end
				endcase
			end
			res_ready <= ($urandom_range(99) >= recv_idle);
		end
		pix_valid <= nv;
		pix       <= np;
		cfg_valid <= ncv;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) @(negedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : main
		int unsigned w, h, we, he, len, cut, noise, rand_count, wait_cycles;
		int drain_at;
		logic need_cfg;

		// Directed: 3x2 frame with an early flush and a late pixel
		push_reg(REG_FRAME_WIDTH, 3);
		push_reg(REG_FRAME_HEIGHT, 2);
		push_item(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
		push_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		push_item(REQ_PIXEL, 8'hAA, 8'h55, 8'h0F);
		push_item(REQ_FLUSH, 8'h12, 8'h34, 8'h56);
		push_item(REQ_PIXEL, 8'hFF, 8'h00, 8'hFF);
		push_item(REQ_PIXEL, 8'h00, 8'hFF, 8'h00);
		push_item(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
		push_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		push_item(REQ_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		push_item(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
		// zero sizes act as a single pixel
		push_reg(REG_FRAME_WIDTH, 0);
		push_reg(REG_FRAME_HEIGHT, 0);
		push_frame(1, 1, 0, 3, -1);
		// tallest frames, cut short
		push_reg(REG_FRAME_WIDTH, 1);
		push_reg(REG_FRAME_HEIGHT, MAX_H);
		push_frame(1, MAX_H, 0, 6, -1);
		push_reg(REG_FRAME_HEIGHT, 8191);
		push_frame(1, MAX_H, 0, 6, -1);
		// widest frame, one row, cut short with a drain partway through
		push_reg(REG_FRAME_HEIGHT, 1);
		push_reg(REG_FRAME_WIDTH, MAX_W);
		push_reg(REG_FRAME_WIDTH, 8191);
		push_frame(MAX_W, 1, 0, 8, 4);

		// Random frames: mostly well formed, some noisy or cut short
		rand_count = 0;
		need_cfg = 1'b1;
		while (rand_count < RANDOM_ITEMS) begin
			if (need_cfg || $urandom_range(99) < 35) begin
				case ($urandom_range(9))
					0: w = 0;
					1: w = $urandom_range(16, 9);
					default: w = $urandom_range(8, 1);
				endcase
				case ($urandom_range(9))
					0: h = 0;
					1: h = $urandom_range(12, 7);
					default: h = $urandom_range(6, 1);
				endcase
				// upper data bits on a width write are don't-care
				if ($urandom_range(99) < 20) w = w | ($urandom_range(3, 1) << FRAME_WIDTH_W);
				if ($urandom_range(1)) begin
					push_reg(REG_FRAME_WIDTH, w);
					push_reg(REG_FRAME_HEIGHT, h);
				end else begin
					push_reg(REG_FRAME_HEIGHT, h);
					push_reg(REG_FRAME_WIDTH, w);
				end
				we = clamp_size(w % (1 << FRAME_WIDTH_W), MAX_W);
				he = clamp_size(h, MAX_H);
			end
			len = we * he + we + 1;
			cut = ($urandom_range(99) < 10) ? $urandom_range(len - 1, 1) : len;
			noise = ($urandom_range(99) < 25) ? 10 : 0;
			drain_at = ($urandom_range(99) < 15) ? int'($urandom_range(cut - 1, 0)) : -1;
			push_frame(we, he, noise, cut, drain_at);
			need_cfg = (cut != len) && ($urandom_range(99) < 80);
			rand_count += cut;
		end

		// Reset once, released at a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait_cycles = 0;
		while ((feed_q.size() != 0 || pix_valid || cfg_valid || blend_expect_q.size() != 0)
				&& wait_cycles < END_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (blend_expect_q.size() != 0) begin
			report_mismatch("results never delivered", '0, blend_expect_q.size());
		end

		$display("Run: %0d items, %0d register writes, %0d pixels checked, %0d frame ends, %0d errors.",
			items_issued, reg_writes, results_checked, frames_seen, error_count);
		$display("Frames from 1x1 up to full height, size clamping, stray flush and pixel items, cut frames.");
		if (error_count == 0 && wait_cycles < END_LIMIT) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/wbb_pkg.sv
hw/rtl/wbb_front.sv
hw/rtl/wbb_queue.sv
hw/rtl/wbb_back.sv
hw/rtl/weighted_blur_blend_filter_core.sv
tb/sv/tb_top.sv
